### design/b64_pkg.sv
// shared types, constants and alphabet lookup for the base64 encoder
package b64_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int SYMS_PER_JOB = 4;

    localparam logic [6:0] PAD_CHAR = 7'h3D;

    localparam logic [1:0] PHASE_0 = 2'd0;
    localparam logic [1:0] PHASE_1 = 2'd1;
    localparam logic [1:0] PHASE_2 = 2'd2;

    typedef struct packed {
        logic       pad;
        logic [5:0] idx;
    } sym_t;

    typedef struct packed {
        sym_t [SYMS_PER_JOB-1:0] syms;
        logic [1:0]              last_sel;
        logic                    fin;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [6:0] b64_char(input logic [5:0] idx);
        logic [6:0] c;
        if (idx < 6'd26) begin
            c = 7'h41 + {1'b0, idx};
        end else if (idx < 6'd52) begin
            c = 7'h61 + {1'b0, idx} - 7'd26;
        end else if (idx < 6'd62) begin
            c = 7'h30 + {1'b0, idx} - 7'd52;
        end else if (idx == 6'd62) begin
            c = 7'h2B;
        end else begin
            c = 7'h2F;
        end
        return c;
    endfunction

endpackage

### design/b64_front.sv
// input side: tracks group phase and leftover bits, turns each byte into a symbol job
module b64_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    input  logic          in_fin,
    input  b64_pkg::q_status_t q_status,
    output logic          push,
    output b64_pkg::job_t push_job
);
    import b64_pkg::*;

    logic [1:0] phase_reg, phase_next;
    logic [3:0] left_reg, left_next;
    job_t       job;

    assign in_ready = !q_status.full;
    assign push     = in_valid && in_ready;
    assign push_job = job;

    always_comb begin
        job        = '0;
        phase_next = phase_reg;
        left_next  = left_reg;
        job.fin    = in_fin;
        case (phase_reg)
            PHASE_1: begin
                job.syms[0].idx = {left_reg[1:0], in_byte[7:4]};
                job.last_sel    = 2'd0;
                phase_next      = PHASE_2;
                left_next       = in_byte[3:0];
                if (in_fin) begin
                    job.syms[1].idx = {in_byte[3:0], 2'b00};
                    job.syms[2].pad = 1'b1;
                    job.last_sel    = 2'd2;
                end
            end
            PHASE_2: begin
                job.syms[0].idx = {left_reg, in_byte[7:6]};
                job.syms[1].idx = in_byte[5:0];
                job.last_sel    = 2'd1;
                phase_next      = PHASE_0;
                left_next       = 4'd0;
            end
            default: begin
                job.syms[0].idx = in_byte[7:2];
                job.last_sel    = 2'd0;
                phase_next      = PHASE_1;
                left_next       = {2'b00, in_byte[1:0]};
                if (in_fin) begin
                    job.syms[1].idx = {in_byte[1:0], 4'b0000};
                    job.syms[2].pad = 1'b1;
                    job.syms[3].pad = 1'b1;
                    job.last_sel    = 2'd3;
                end
            end
        endcase
        if (in_fin) begin
            phase_next = PHASE_0;
            left_next  = 4'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PHASE_0;
            left_reg  <= 4'd0;
        end else if (push) begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

endmodule

### design/b64_queue.sv
// short job queue between the front and back parts
module b64_queue #(
    parameter int DEPTH = b64_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  b64_pkg::job_t      push_job,
    input  logic               pop,
    output b64_pkg::job_t      head_job,
    output b64_pkg::q_status_t status
);
    import b64_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign status.full  = (cnt_reg == CNT_W'(DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_job     = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### design/b64_back.sv
// output side: walks the symbols of the head job, maps them to ascii, holds the output register
module b64_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  b64_pkg::job_t      head_job,
    input  b64_pkg::q_status_t q_status,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [6:0]         out_char,
    output logic               out_fin
);
    import b64_pkg::*;

    logic [1:0] sel_reg, sel_next;
    logic       valid_reg, valid_next;
    logic [6:0] char_reg, char_next;
    logic       fin_reg, fin_next;
    logic       load, take, last_sym;
    sym_t       cur;

    assign load     = !valid_reg || out_ready;
    assign take     = load && !q_status.empty;
    assign cur      = head_job.syms[sel_reg];
    assign last_sym = (sel_reg == head_job.last_sel);
    assign pop      = take && last_sym;

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_fin   = fin_reg;

    always_comb begin
        sel_next   = sel_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        fin_next   = fin_reg;
        if (load) begin
            valid_next = take;
            if (take) begin
                char_next = cur.pad ? PAD_CHAR : b64_char(cur.idx);
                fin_next  = last_sym && head_job.fin;
                sel_next  = last_sym ? 2'd0 : sel_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            sel_reg   <= sel_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg <= char_next;
        fin_reg  <= fin_next;
    end

endmodule

### design/base64_encoder.sv
// base64 encoder top level: front, job queue and output serializer
//
// Streaming base64 encoder, standard alphabet with '=' padding.
// Input channel s_axis: one raw byte per transfer in tdata, tlast on the
// last byte of a message. Output channel m_axis: one ascii character per
// transfer in tdata[6:0], tlast on the last character of the message.
// Each byte becomes a job of one to four symbols in the front part; the
// back part emits one character per cycle from the head of the job queue
// while the queue holds a job and the receiver is ready. On its way to
// m_axis a byte's first character passes the queue entry written when
// the byte is taken, then the output register. A steady stream gives
// four characters per three bytes; a single byte can be taken every
// cycle while the queue has room. The output port rate bounds the
// sustained throughput. Reset clears the group phase, the queue and the
// output valid flag; the next byte starts a new message. When the
// receiver stalls, the output register holds its character, the queue
// fills, and s_axis_tready drops once all queue entries are in use.
module base64_encoder #(
    parameter int QUEUE_DEPTH = b64_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] out_char, [7] zero
    output logic       m_axis_tlast
);
    import b64_pkg::*;

    job_t      push_job, head_job;
    q_status_t q_status;
    logic      push, pop;
    logic [6:0] out_char;

    b64_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .in_fin   (s_axis_tlast),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    b64_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    b64_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_job  (head_job),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_char  (out_char),
        .out_fin   (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_char};

`ifndef NO_ASSERTIONS
    a_queue_status: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty together");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_status.full)
        else $error("job pushed into a full queue");

    a_pop_needs_job: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_status.empty)
        else $error("job popped from an empty queue");

    a_load_on_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (!q_status.empty && (!m_axis_tvalid || m_axis_tready)) |=> m_axis_tvalid)
        else $error("pending job not moved into the output register");
`endif

endmodule
